@@ hdl/tty_pkg.sv @@
// Shared types and constants for the terminal line queue block.
package tty_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 64;
    localparam int BYTE_W              = 8;
    localparam logic ECHO_ENABLE_RESET = 1'b1;

    typedef enum logic [1:0] {
        FUNC_RX_BYTE  = 2'd0,
        FUNC_TX_READY = 2'd1,
        FUNC_HOST_WR  = 2'd2,
        FUNC_HOST_RD  = 2'd3
    } func_t;

endpackage

@@ hdl/tty_ram.sv @@
// Simple dual-port byte memory with one write port and one registered read port.
module tty_ram #(
    parameter int DEPTH = tty_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [tty_pkg::BYTE_W-1:0]  wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [tty_pkg::BYTE_W-1:0]  rdata
);
    import tty_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/tty_ctrl.sv @@
// Queue pointers, item sequencing and the result register.
module tty_ctrl #(
    parameter int DEPTH = tty_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int AW    = $clog2(DEPTH),
    parameter int BW    = $clog2(2 * DEPTH)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_func,
    input  logic [tty_pkg::BYTE_W-1:0]  s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_tx_valid,
    output logic [tty_pkg::BYTE_W-1:0]  m_tx_byte,
    output logic                        m_read_valid,
    output logic [tty_pkg::BYTE_W-1:0]  m_read_byte,
    output logic                        m_write_accepted,
    output logic                        m_tx_irq_enable,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data,
    // Receive queue memory.
    output logic                        rx_we,
    output logic [AW-1:0]               rx_waddr,
    output logic [tty_pkg::BYTE_W-1:0]  rx_wdata,
    output logic                        rx_re,
    output logic [AW-1:0]               rx_raddr,
    input  logic [tty_pkg::BYTE_W-1:0]  rx_rdata,
    // Transmit side memory: write queue in the lower half, echo queue in the upper.
    output logic                        tx_we,
    output logic [BW-1:0]               tx_waddr,
    output logic [tty_pkg::BYTE_W-1:0]  tx_wdata,
    output logic                        tx_re,
    output logic [BW-1:0]               tx_raddr,
    input  logic [tty_pkg::BYTE_W-1:0]  tx_rdata
);
    import tty_pkg::*;

    localparam int FW = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

    state_t          state_reg, state_next;
    logic            pop_tx_reg, pop_tx_next;
    logic [AW-1:0]   read_head_reg, read_head_next;
    logic [FW-1:0]   read_fill_reg, read_fill_next;
    logic [AW-1:0]   write_head_reg, write_head_next;
    logic [FW-1:0]   write_fill_reg, write_fill_next;
    logic [AW-1:0]   echo_head_reg, echo_head_next;
    logic [FW-1:0]   echo_fill_reg, echo_fill_next;
    logic            tx_en_reg, tx_en_next;
    logic            echo_en_reg, echo_en_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_txv_reg, out_txv_next;
    logic [BYTE_W-1:0] out_txb_reg, out_txb_next;
    logic              out_rdv_reg, out_rdv_next;
    logic [BYTE_W-1:0] out_rdb_reg, out_rdb_next;
    logic              out_wok_reg, out_wok_next;
    logic              out_irq_reg, out_irq_next;

    logic s_xfer;

    function automatic logic [AW-1:0] tail_of(input logic [AW-1:0] head,
                                              input logic [FW-1:0] fill);
        logic [AW:0] sum;
        sum = {1'b0, head} + (AW + 1)'(fill);
        if (sum >= (AW + 1)'(DEPTH)) begin
            sum = sum - (AW + 1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] head_inc(input logic [AW-1:0] head);
        logic [AW-1:0] nxt;
        if (head == AW'(DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = head + AW'(1);
        end
        return nxt;
    endfunction

    function automatic logic [BW-1:0] tx_addr(input logic echo_sel,
                                              input logic [AW-1:0] idx);
        logic [BW-1:0] a;
        a = BW'(idx);
        if (echo_sel) begin
            a = a + BW'(DEPTH);
        end
        return a;
    endfunction

    // A new item may enter when no pop is in flight and the result slot is empty or frees this cycle.
    assign s_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next      = state_reg;
        pop_tx_next     = pop_tx_reg;
        read_head_next  = read_head_reg;
        read_fill_next  = read_fill_reg;
        write_head_next = write_head_reg;
        write_fill_next = write_fill_reg;
        echo_head_next  = echo_head_reg;
        echo_fill_next  = echo_fill_reg;
        tx_en_next      = tx_en_reg;
        echo_en_next    = echo_en_reg;

        out_valid_next = out_valid_reg && !m_ready;
        out_txv_next   = out_txv_reg;
        out_txb_next   = out_txb_reg;
        out_rdv_next   = out_rdv_reg;
        out_rdb_next   = out_rdb_reg;
        out_wok_next   = out_wok_reg;
        out_irq_next   = out_irq_reg;

        rx_we    = 1'b0;
        rx_waddr = tail_of(read_head_reg, read_fill_reg);
        rx_wdata = s_data;
        rx_re    = 1'b0;
        rx_raddr = read_head_reg;
        tx_we    = 1'b0;
        tx_waddr = tx_addr(1'b1, tail_of(echo_head_reg, echo_fill_reg));
        tx_wdata = s_data;
        tx_re    = 1'b0;
        tx_raddr = tx_addr(1'b1, echo_head_reg);

        if (cfg_valid) begin
            echo_en_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    // Default result; pops replace it once the memory answers.
                    out_valid_next = 1'b1;
                    out_txv_next   = 1'b0;
                    out_txb_next   = '0;
                    out_rdv_next   = 1'b0;
                    out_rdb_next   = '0;
                    out_wok_next   = 1'b0;
                    unique case (func_t'(s_func))
                        FUNC_RX_BYTE: begin
                            if (read_fill_reg != FW'(DEPTH)) begin
                                rx_we          = 1'b1;
                                read_fill_next = read_fill_reg + FW'(1);
                            end
                            if (echo_en_reg) begin
                                tx_en_next = 1'b1;
                                if (echo_fill_reg != FW'(DEPTH)) begin
                                    tx_we          = 1'b1;
                                    echo_fill_next = echo_fill_reg + FW'(1);
                                end
                            end
                        end
                        FUNC_TX_READY: begin
                            if (echo_fill_reg != '0) begin
                                tx_re          = 1'b1;
                                echo_head_next = head_inc(echo_head_reg);
                                echo_fill_next = echo_fill_reg - FW'(1);
                                tx_en_next     = 1'b1;
                                pop_tx_next    = 1'b1;
                                out_valid_next = 1'b0;
                                state_next     = ST_POP;
                            end else if (write_fill_reg != '0) begin
                                tx_re           = 1'b1;
                                tx_raddr        = tx_addr(1'b0, write_head_reg);
                                write_head_next = head_inc(write_head_reg);
                                write_fill_next = write_fill_reg - FW'(1);
                                tx_en_next      = 1'b1;
                                pop_tx_next     = 1'b1;
                                out_valid_next  = 1'b0;
                                state_next      = ST_POP;
                            end else begin
                                tx_en_next = 1'b0;
                            end
                        end
                        FUNC_HOST_WR: begin
                            tx_en_next = 1'b1;
                            if (write_fill_reg != FW'(DEPTH)) begin
                                tx_we           = 1'b1;
                                tx_waddr        = tx_addr(1'b0,
                                                  tail_of(write_head_reg, write_fill_reg));
                                write_fill_next = write_fill_reg + FW'(1);
                                out_wok_next    = 1'b1;
                            end
                        end
                        FUNC_HOST_RD: begin
                            if (read_fill_reg != '0) begin
                                rx_re          = 1'b1;
                                read_head_next = head_inc(read_head_reg);
                                read_fill_next = read_fill_reg - FW'(1);
                                pop_tx_next    = 1'b0;
                                out_valid_next = 1'b0;
                                state_next     = ST_POP;
                            end
                        end
                        default: begin
                        end
                    endcase
                    out_irq_next = tx_en_next;
                end
            end
            ST_POP: begin
                // The result slot was freed when the pop was accepted.
                out_valid_next = 1'b1;
                out_txv_next   = pop_tx_reg;
                out_txb_next   = pop_tx_reg ? tx_rdata : '0;
                out_rdv_next   = !pop_tx_reg;
                out_rdb_next   = pop_tx_reg ? '0 : rx_rdata;
                out_wok_next   = 1'b0;
                out_irq_next   = tx_en_reg;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            read_head_reg  <= '0;
            read_fill_reg  <= '0;
            write_head_reg <= '0;
            write_fill_reg <= '0;
            echo_head_reg  <= '0;
            echo_fill_reg  <= '0;
            tx_en_reg      <= 1'b0;
            echo_en_reg    <= ECHO_ENABLE_RESET;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            read_head_reg  <= read_head_next;
            read_fill_reg  <= read_fill_next;
            write_head_reg <= write_head_next;
            write_fill_reg <= write_fill_next;
            echo_head_reg  <= echo_head_next;
            echo_fill_reg  <= echo_fill_next;
            tx_en_reg      <= tx_en_next;
            echo_en_reg    <= echo_en_next;
            out_valid_reg  <= out_valid_next;
        end
        pop_tx_reg  <= pop_tx_next;
        out_txv_reg <= out_txv_next;
        out_txb_reg <= out_txb_next;
        out_rdv_reg <= out_rdv_next;
        out_rdb_reg <= out_rdb_next;
        out_wok_reg <= out_wok_next;
        out_irq_reg <= out_irq_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_tx_valid       = out_txv_reg;
    assign m_tx_byte        = out_txb_reg;
    assign m_read_valid     = out_rdv_reg;
    assign m_read_byte      = out_rdb_reg;
    assign m_write_accepted = out_wok_reg;
    assign m_tx_irq_enable  = out_irq_reg;

endmodule

@@ hdl/tty_echo_priority_queues.sv @@
// Top level of the terminal line queue block: controller and two queue memories.
//
// Three byte queues of QUEUE_DEPTH entries (receive, host write, echo) sit in two
// synchronous memories: the receive queue in one, the write and echo queues in the
// two halves of the other, so a received byte can go to the receive and echo queues
// in the same cycle. A received byte, a host write, an empty host read and a
// transmitter-ready with nothing queued skip the pop state: a new transfer can be
// accepted every cycle while results are taken. A host read or a transmitter-ready
// that pops a byte also passes the pop state; the queue memory read is registered.
// Results are held in an output register, so input transfers continue while
// the previous result is taken. No clearing pass is run after reset; the queues start
// empty from their fill counts. The echo enable register resets to 1 and is written
// through the cfg channel, which is always ready.
module tty_echo_priority_queues #(
    parameter int QUEUE_DEPTH = tty_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_func,
    input  logic [tty_pkg::BYTE_W-1:0]  s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_tx_valid,
    output logic [tty_pkg::BYTE_W-1:0]  m_tx_byte,
    output logic                        m_read_valid,
    output logic [tty_pkg::BYTE_W-1:0]  m_read_byte,
    output logic                        m_write_accepted,
    output logic                        m_tx_irq_enable,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data
);
    import tty_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int BW = $clog2(2 * QUEUE_DEPTH);

    logic              rx_we, rx_re, tx_we, tx_re;
    logic [AW-1:0]     rx_waddr, rx_raddr;
    logic [BW-1:0]     tx_waddr, tx_raddr;
    logic [BYTE_W-1:0] rx_wdata, rx_rdata, tx_wdata, tx_rdata;

    tty_ctrl #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .BW    (BW)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_tx_valid       (m_tx_valid),
        .m_tx_byte        (m_tx_byte),
        .m_read_valid     (m_read_valid),
        .m_read_byte      (m_read_byte),
        .m_write_accepted (m_write_accepted),
        .m_tx_irq_enable  (m_tx_irq_enable),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .rx_we            (rx_we),
        .rx_waddr         (rx_waddr),
        .rx_wdata         (rx_wdata),
        .rx_re            (rx_re),
        .rx_raddr         (rx_raddr),
        .rx_rdata         (rx_rdata),
        .tx_we            (tx_we),
        .tx_waddr         (tx_waddr),
        .tx_wdata         (tx_wdata),
        .tx_re            (tx_re),
        .tx_raddr         (tx_raddr),
        .tx_rdata         (tx_rdata)
    );

    tty_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (rx_wdata),
        .re    (rx_re),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    tty_ram #(
        .DEPTH (2 * QUEUE_DEPTH),
        .AW    (BW)
    ) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (tx_wdata),
        .re    (tx_re),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

endmodule

@@ hdl/tty_checker.sv @@
// Port-level checks for the terminal line queue block, bound to its top level.
module tty_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_tx_valid,
    input logic [tty_pkg::BYTE_W-1:0]  m_tx_byte,
    input logic                        m_read_valid,
    input logic [tty_pkg::BYTE_W-1:0]  m_read_byte,
    input logic                        m_write_accepted,
    input logic                        m_tx_irq_enable
);
    import tty_pkg::*;

    // An input transfer never happens while a result is stuck in the output register.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !m_valid || m_ready)
        else $error("input transfer while result stalled");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_byte) && $stable(m_read_byte)
            && $stable(m_tx_valid) && $stable(m_read_valid))
        else $error("stalled result changed");

    // Sending a byte always leaves transmit interrupts enabled.
    a_tx_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tx_valid |-> m_tx_irq_enable && !m_read_valid && !m_write_accepted)
        else $error("transmit result with inconsistent flags");

    a_write_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_write_accepted |-> m_tx_irq_enable && !m_read_valid)
        else $error("accepted write without transmit enable");

    a_idle_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_tx_valid || m_tx_byte == '0) && (m_read_valid || m_read_byte == '0))
        else $error("byte field set without its valid flag");

endmodule

bind tty_echo_priority_queues tty_checker u_tty_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_tx_valid       (m_tx_valid),
    .m_tx_byte        (m_tx_byte),
    .m_read_valid     (m_read_valid),
    .m_read_byte      (m_read_byte),
    .m_write_accepted (m_write_accepted),
    .m_tx_irq_enable  (m_tx_irq_enable)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the terminal line queue block with echo and priority transmit.
module tb_top;
    import tty_pkg::*;

    localparam int DEPTH       = DEFAULT_QUEUE_DEPTH;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLDOFF_LEN = 400;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        func_t             func;
        logic [BYTE_W-1:0] data;
    } line_item_t;

    typedef struct packed {
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              read_valid;
        logic [BYTE_W-1:0] read_byte;
        logic              write_accepted;
        logic              tx_irq_enable;
    } line_result_t;

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    logic [1:0]        s_func    = '0;
    logic [BYTE_W-1:0] s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic              m_tx_valid;
    logic [BYTE_W-1:0] m_tx_byte;
    logic              m_read_valid;
    logic [BYTE_W-1:0] m_read_byte;
    logic              m_write_accepted;
    logic              m_tx_irq_enable;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_data  = 1'b0;

    // Shadow copy of the three byte queues and the two flags.
    logic [BYTE_W-1:0] rx_fifo[$];
    logic [BYTE_W-1:0] host_fifo[$];
    logic [BYTE_W-1:0] echo_fifo[$];
    logic              tx_irq_en = 1'b0;
    logic              echo_on   = ECHO_ENABLE_RESET;

    line_item_t   pending_items[$];
    line_result_t due_results[$];

    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int holdoff_requests = 0;
    int holdoff_served   = 0;
    int holdoff_left     = 0;
    int mismatch_count   = 0;
    int cycle_count      = 0;

    tty_echo_priority_queues #(
        .QUEUE_DEPTH(DEPTH)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_tx_valid      (m_tx_valid),
        .m_tx_byte       (m_tx_byte),
        .m_read_valid    (m_read_valid),
        .m_read_byte     (m_read_byte),
        .m_write_accepted(m_write_accepted),
        .m_tx_irq_enable (m_tx_irq_enable),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic line_result_t next_line_result(func_t func, logic [BYTE_W-1:0] data);
        line_result_t r;
        r = '0;
        case (func)
            FUNC_RX_BYTE: begin
                if (rx_fifo.size() < DEPTH) rx_fifo.push_back(data);
                // The enable is set even when the echo copy is dropped.
                if (echo_on) begin
                    if (echo_fifo.size() < DEPTH) echo_fifo.push_back(data);
                    tx_irq_en = 1'b1;
                end
            end
            FUNC_TX_READY: begin
                if (echo_fifo.size() != 0) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = echo_fifo.pop_front();
                    tx_irq_en  = 1'b1;
                end else if (host_fifo.size() != 0) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = host_fifo.pop_front();
                    tx_irq_en  = 1'b1;
                end else begin
                    tx_irq_en = 1'b0;
                end
            end
            FUNC_HOST_WR: begin
                if (host_fifo.size() < DEPTH) begin
                    host_fifo.push_back(data);
                    r.write_accepted = 1'b1;
                end
                tx_irq_en = 1'b1;
            end
            default: begin
                if (rx_fifo.size() != 0) begin
                    r.read_valid = 1'b1;
                    r.read_byte  = rx_fifo.pop_front();
                end
            end
        endcase
        r.tx_irq_enable = tx_irq_en;
        return r;
    endfunction

    function automatic void log_mismatch(string what, int want, int got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch on %0s: expected %0h, got %0h", what, want, got);
    endfunction

    function automatic void check_field(string what, logic [BYTE_W-1:0] want,
                                        logic [BYTE_W-1:0] got);
        if (want !== got) log_mismatch(what, int'(want), int'(got));
    endfunction

    // Input driver: presents queued items and predicts each one at its transfer.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                due_results.push_back(next_line_result(func_t'(s_func), s_data));
                void'(pending_items.pop_front());
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_func  <= pending_items[0].func;
                    s_data  <= pending_items[0].data;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (holdoff_served != holdoff_requests) begin
            holdoff_served = holdoff_requests;
            holdoff_left   = HOLDOFF_LEN;
            m_ready <= 1'b0;
        end else if (holdoff_left != 0) begin
            holdoff_left = holdoff_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        line_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                log_mismatch("result with none due", 0, 1);
            end else begin
                want = due_results.pop_front();
                check_field("tx_valid", BYTE_W'(want.tx_valid), BYTE_W'(m_tx_valid));
                check_field("tx_byte", want.tx_byte, m_tx_byte);
                check_field("read_valid", BYTE_W'(want.read_valid), BYTE_W'(m_read_valid));
                check_field("read_byte", want.read_byte, m_read_byte);
                check_field("write_accepted", BYTE_W'(want.write_accepted),
                            BYTE_W'(m_write_accepted));
                check_field("tx_irq_enable", BYTE_W'(want.tx_irq_enable),
                            BYTE_W'(m_tx_irq_enable));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add_item(input func_t func, input logic [BYTE_W-1:0] data);
        line_item_t item;
        item.func = func;
        item.data = data;
        pending_items.push_back(item);
    endtask

    task automatic wait_for_quiet();
        while (pending_items.size() != 0 || due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_echo(input logic value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        echo_on = value;
        cfg_valid <= 1'b0;
    endtask

    // Runs of traffic biased toward filling or draining queues, so that full
    // and empty queues are both reached often.
    task automatic queue_traffic(input int count);
        int    kind;
        int    run;
        int    roll;
        func_t func;
        while (count > 0) begin
            kind = $urandom_range(3);
            run  = $urandom_range(90, 1);
            if (run > count) run = count;
            count -= run;
            repeat (run) begin
                roll = $urandom_range(99);
                case (kind)
                    0: func = (roll < 85) ? FUNC_RX_BYTE : func_t'($urandom_range(3));
                    1: func = (roll < 85) ? FUNC_HOST_WR : func_t'($urandom_range(3));
                    2: begin
                        if (roll < 90) func = roll[0] ? FUNC_TX_READY : FUNC_HOST_RD;
                        else func = func_t'($urandom_range(3));
                    end
                    default: func = func_t'($urandom_range(3));
                endcase
                add_item(func, BYTE_W'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 25;
        recv_idle_pct = 45;

        // Empty queues, transmitter ready while the enable is still clear, data extremes.
        add_item(FUNC_HOST_RD, 8'hFF);
        add_item(FUNC_TX_READY, 8'hFF);
        add_item(FUNC_RX_BYTE, 8'h00);
        add_item(FUNC_RX_BYTE, 8'hFF);
        add_item(FUNC_HOST_WR, 8'hA5);
        add_item(FUNC_HOST_WR, 8'h5A);
        add_item(FUNC_TX_READY, 8'h00);
        add_item(FUNC_TX_READY, 8'h00);
        add_item(FUNC_TX_READY, 8'hFF);
        add_item(FUNC_HOST_RD, 8'h00);
        add_item(FUNC_HOST_RD, 8'h00);
        add_item(FUNC_HOST_RD, 8'h00);
        add_item(FUNC_TX_READY, 8'h00);
        add_item(FUNC_TX_READY, 8'h00);
        wait_for_quiet();

        // With echo off a received byte reaches only the read queue.
        set_echo(1'b0);
        add_item(FUNC_RX_BYTE, 8'h81);
        add_item(FUNC_TX_READY, 8'h00);
        add_item(FUNC_HOST_WR, 8'h7E);
        add_item(FUNC_TX_READY, 8'h00);
        add_item(FUNC_HOST_RD, 8'h00);
        wait_for_quiet();

        set_echo(1'b1);
        queue_traffic(260);
        wait_for_quiet();
        set_echo(1'b0);
        queue_traffic(260);
        wait_for_quiet();

        send_idle_pct = 45;
        recv_idle_pct = 25;
        set_echo(1'b1);
        queue_traffic(260);
        wait_for_quiet();
        set_echo(1'b0);
        queue_traffic(260);
        wait_for_quiet();

        // No idling; the receiver holds off at first so that the block backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_echo(1'b1);
        holdoff_requests++;
        queue_traffic(260);
        wait_for_quiet();
        set_echo(1'b0);
        queue_traffic(250);

        wait_for_quiet();
        repeat (10) @(posedge aclk);
        if (due_results.size() != 0)
            log_mismatch("results never delivered", due_results.size(), 0);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/tty_pkg.sv
hdl/tty_ram.sv
hdl/tty_ctrl.sv
hdl/tty_echo_priority_queues.sv
hdl/tty_checker.sv
tb/tb_top.sv
